>>> src/pen_sample_ring_queue_macros.svh
// Assertion macros shared by the pen sample ring queue RTL.
`ifndef PEN_SAMPLE_RING_QUEUE_MACROS_SVH
`define PEN_SAMPLE_RING_QUEUE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define PSRQ_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define PSRQ_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/psrq_pkg.sv
// Types and fixed constants shared by the pen sample ring queue modules.
package psrq_pkg;

    localparam int unsigned WORD_W    = 32;
    localparam int unsigned OFFSET_W  = 8;
    localparam int unsigned OFFSET_N  = 2 ** OFFSET_W;
    localparam int unsigned CMD_W     = 4;
    localparam int unsigned STATUS_W  = 2;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [WORD_W-1:0] FILL_WORD     = 32'h1400_0000;
    localparam logic [WORD_W-1:0] WRITING_LIMIT = 32'd8;

    // Register reset values
    localparam logic [WORD_W-1:0] PEN_DOWN_RST = 32'd13;
    localparam logic [WORD_W-1:0] PEN_UP_RST   = 32'd14;
    localparam logic [WORD_W-1:0] INVALID_RST  = 32'hFFFF_FFFF;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_POLL_ONLY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PEN_DOWN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PEN_UP    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INVALID   = 2'd3;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_READY = 2'd2;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT      = 4'd0,
        CMD_POLL        = 4'd1,
        CMD_INK_RD      = 4'd2,
        CMD_INK_WR      = 4'd3,
        CMD_INK_ADV     = 4'd4,
        CMD_STROKE_RD   = 4'd5,
        CMD_STROKE_ADV  = 4'd6,
        CMD_FLUSH       = 4'd7,
        CMD_DROP_STROKE = 4'd8
    } t_cmd;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DECODE,
        S_INSERT,
        S_FINISH
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic load;       // latch the request
        logic exec;       // run a non-insert, non-read command
        logic rd;         // read the store at the reader address
        logic ins_write;  // write one insert word, commit on the last one
        logic poll_upd;   // poll-only insert
        logic set_full;   // insert rejected
        logic finish;     // register the result
    } t_dp_ctrl;

    // Datapath to controller status
    typedef struct packed {
        logic is_insert;
        logic is_read;
        logic poll_only;
        logic full;
        logic last_word;
    } t_dp_stat;

endpackage

>>> src/psrq_ctrl.sv
// Request sequencer for the pen sample ring queue.
module psrq_ctrl
    import psrq_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    input  t_dp_stat i_stat,
    output t_dp_ctrl o_ctrl,
    output logic     busy
);

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start) n_state = S_DECODE;
            end
            S_DECODE: begin
                if (i_stat.is_insert && !i_stat.poll_only && !i_stat.full) begin
                    n_state = S_INSERT;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_INSERT: begin
                if (i_stat.last_word) n_state = S_FINISH;
            end
            S_FINISH: begin
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Commands to the datapath
    always_comb begin
        o_ctrl = '0;
        unique case (r_state)
            S_IDLE: begin
                o_ctrl.load = start;
            end
            S_DECODE: begin
                priority if (i_stat.is_insert) begin
                    if (i_stat.poll_only) begin
                        o_ctrl.poll_upd = 1'b1;
                    end else if (i_stat.full) begin
                        o_ctrl.set_full = 1'b1;
                    end
                end else if (i_stat.is_read) begin
                    o_ctrl.rd = 1'b1;
                end else begin
                    o_ctrl.exec = 1'b1;
                end
            end
            S_INSERT: begin
                o_ctrl.ins_write = 1'b1;
            end
            S_FINISH: begin
                o_ctrl.finish = 1'b1;
            end
            default: o_ctrl = '0;
        endcase
    end

    assign busy = (r_state != S_IDLE);

endmodule

>>> src/psrq_datapath.sv
// Ring store, reader/writer indexes, poll record and result registers.
module psrq_datapath
    import psrq_pkg::*;
#(
    parameter int BUFFER_DEPTH   = 256,
    parameter int PRESSURE_SHIFT = 0,
    parameter int PRESSURE_BITS  = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_dp_ctrl             i_ctrl,
    output t_dp_stat             o_stat,
    // configuration
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [WORD_W-1:0]    i_cfg_data,
    // request
    input  logic [CMD_W-1:0]     i_cmd,
    input  logic [WORD_W-1:0]    i_sample_word,
    input  logic [WORD_W-1:0]    i_sample_time,
    input  logic [WORD_W-1:0]    i_current_ticks,
    input  logic [OFFSET_W-1:0]  i_offset,
    input  logic [WORD_W-1:0]    i_write_data,
    // result
    output logic                 o_done,
    output logic [STATUS_W-1:0]  o_status,
    output logic [WORD_W-1:0]    o_read_data,
    output logic [WORD_W-1:0]    o_poll_sample,
    output logic                 o_pen_is_up,
    output logic                 o_all_empty,
    output logic                 o_inker_empty,
    output logic                 o_stroker_empty
);

    localparam int IW = $clog2(BUFFER_DEPTH);
    localparam logic [IW:0]   DEPTH_X = (IW+1)'(BUFFER_DEPTH);
    localparam logic [IW-1:0] LAST_IX = IW'(BUFFER_DEPTH - 1);

    // Configuration registers
    logic              r_poll_only;
    logic [WORD_W-1:0] r_pen_down_code;
    logic [WORD_W-1:0] r_pen_up_code;
    logic [WORD_W-1:0] r_invalid_code;

    // Queue and poll state
    logic [IW-1:0]     r_write_idx,  n_write_idx;
    logic [IW-1:0]     r_ink_idx,    n_ink_idx;
    logic [IW-1:0]     r_stroke_idx, n_stroke_idx;
    logic [WORD_W-1:0] r_last_sample, n_last_sample;
    logic              r_pen_up,      n_pen_up;
    logic              r_poll_ready,  n_poll_ready;

    // Latched request
    t_cmd              r_cmd;
    logic [WORD_W-1:0] r_word;
    logic [WORD_W-1:0] r_stamp;
    logic [IW-1:0]     r_off_mod;
    logic [WORD_W-1:0] r_wdata;
    logic [IW-1:0]     r_wptr;
    logic [1:0]        r_wcnt;
    logic [STATUS_W-1:0] r_status;

    // Store
    logic [WORD_W-1:0] r_mem [BUFFER_DEPTH];
    logic [WORD_W-1:0] r_mem_q;

    // Result registers
    logic                r_done;
    logic [STATUS_W-1:0] r_res_status;
    logic [WORD_W-1:0]   r_res_rdata;
    logic [WORD_W-1:0]   r_res_sample;
    logic                r_res_pen_up;
    logic                r_res_all_empty;
    logic                r_res_ink_empty;
    logic                r_res_stroke_empty;

    // Offset reduced modulo the depth, built at elaboration
    logic [IW-1:0] w_off_tab [OFFSET_N];
    for (genvar g = 0; g < OFFSET_N; g++) begin : g_off_tab
        localparam int unsigned OffMod = g % BUFFER_DEPTH;
        assign w_off_tab[g] = IW'(OffMod);
    end

    // Reader address: base plus offset, wrapped
    logic [IW-1:0] w_base;
    logic [IW:0]   w_acc_sum;
    logic [IW-1:0] w_acc_addr;
    assign w_base = (r_cmd == CMD_STROKE_RD || r_cmd == CMD_STROKE_ADV) ?
                    r_stroke_idx : r_ink_idx;
    assign w_acc_sum  = {1'b0, w_base} + {1'b0, r_off_mod};
    assign w_acc_addr = (w_acc_sum >= DEPTH_X) ? IW'(w_acc_sum - DEPTH_X) : IW'(w_acc_sum);

    // Insert word count and word select
    logic [1:0]        w_n_last;
    logic [WORD_W-1:0] w_ins_word;
    always_comb begin
        priority if (r_word == r_pen_down_code) w_n_last = 2'd1;
        else if (r_word == r_pen_up_code)       w_n_last = 2'd3;
        else                                    w_n_last = 2'd0;
    end
    always_comb begin
        unique case (r_wcnt)
            2'd0:    w_ins_word = r_word;
            2'd1:    w_ins_word = r_stamp;
            default: w_ins_word = FILL_WORD;
        endcase
    end

    logic [IW-1:0] w_wptr_next;
    assign w_wptr_next = (r_wptr == LAST_IX) ? '0 : r_wptr + 1'b1;

    // Free slots before the writer would reach the stroker
    logic [IW:0] w_free;
    logic        w_full;
    always_comb begin
        if (r_stroke_idx > r_write_idx) begin
            w_free = {1'b0, r_stroke_idx} - {1'b0, r_write_idx} - 1'b1;
        end else begin
            w_free = {1'b0, r_stroke_idx} + DEPTH_X - {1'b0, r_write_idx} - 1'b1;
        end
    end
    assign w_full = ((IW+1)'(w_n_last) >= w_free);

    // Pressure field
    logic [WORD_W-1:0]        w_shifted;
    logic [PRESSURE_BITS-1:0] w_press;
    logic [WORD_W-1:0]        w_press_x;
    assign w_shifted = r_word >> PRESSURE_SHIFT;
    assign w_press   = w_shifted[PRESSURE_BITS-1:0];
    assign w_press_x = WORD_W'(w_press);

    logic w_commit;
    logic w_poll_apply;
    assign w_commit     = i_ctrl.ins_write && (r_wcnt == w_n_last);
    assign w_poll_apply = (w_commit || i_ctrl.poll_upd) && (r_word != r_invalid_code);

    // Status to controller
    assign o_stat.is_insert = (r_cmd == CMD_INSERT);
    assign o_stat.is_read   = (r_cmd == CMD_INK_RD || r_cmd == CMD_STROKE_RD);
    assign o_stat.poll_only = r_poll_only;
    assign o_stat.full      = w_full;
    assign o_stat.last_word = (r_wcnt == w_n_last);

    // Index updates
    always_comb begin
        n_write_idx  = r_write_idx;
        n_ink_idx    = r_ink_idx;
        n_stroke_idx = r_stroke_idx;
        if (w_commit) n_write_idx = w_wptr_next;
        if (i_ctrl.exec) begin
            unique case (r_cmd)
                CMD_INK_ADV:     n_ink_idx    = w_acc_addr;
                CMD_STROKE_ADV:  n_stroke_idx = w_acc_addr;
                CMD_FLUSH: begin
                    n_ink_idx    = r_write_idx;
                    n_stroke_idx = r_write_idx;
                end
                CMD_DROP_STROKE: n_stroke_idx = r_ink_idx;
                default: ;
            endcase
        end
    end

    // Poll record updates
    always_comb begin
        n_last_sample = r_last_sample;
        n_pen_up      = r_pen_up;
        n_poll_ready  = r_poll_ready;
        if (w_poll_apply) begin
            n_last_sample = r_word;
            priority if (w_press_x == r_pen_up_code) begin
                if (!r_pen_up) begin
                    n_pen_up     = 1'b1;
                    n_poll_ready = 1'b1;
                end
            end else if (w_press_x == r_pen_down_code) begin
                n_pen_up = 1'b0;
            end else if (w_press_x < WRITING_LIMIT) begin
                n_pen_up     = 1'b0;
                n_poll_ready = 1'b1;
            end else begin
                n_pen_up = r_pen_up;  // other pressures keep the pen state
            end
        end
        if (i_ctrl.exec && r_cmd == CMD_POLL) n_poll_ready = 1'b0;
        if (i_cfg_we && i_cfg_idx == CFG_POLL_ONLY) n_poll_ready = 1'b0;
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poll_only     <= 1'b0;
            r_pen_down_code <= PEN_DOWN_RST;
            r_pen_up_code   <= PEN_UP_RST;
            r_invalid_code  <= INVALID_RST;
            r_write_idx     <= '0;
            r_ink_idx       <= '0;
            r_stroke_idx    <= '0;
            r_last_sample   <= '0;
            r_pen_up        <= 1'b1;
            r_poll_ready    <= 1'b0;
            r_done          <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_POLL_ONLY: r_poll_only     <= i_cfg_data[0];
                    CFG_PEN_DOWN:  r_pen_down_code <= i_cfg_data;
                    CFG_PEN_UP:    r_pen_up_code   <= i_cfg_data;
                    CFG_INVALID:   r_invalid_code  <= i_cfg_data;
                    default: ;
                endcase
            end
            r_write_idx   <= n_write_idx;
            r_ink_idx     <= n_ink_idx;
            r_stroke_idx  <= n_stroke_idx;
            r_last_sample <= n_last_sample;
            r_pen_up      <= n_pen_up;
            r_poll_ready  <= n_poll_ready;
            r_done        <= i_ctrl.finish;
        end
    end

    // Request latch, insert pointer and status
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_cmd     <= t_cmd'(i_cmd);
            r_word    <= i_sample_word;
            r_stamp   <= (i_sample_time != '0) ? i_sample_time : i_current_ticks;
            r_off_mod <= w_off_tab[i_offset];
            r_wdata   <= i_write_data;
            r_wptr    <= r_write_idx;
            r_wcnt    <= '0;
            r_status  <= ST_OK;
        end else begin
            if (i_ctrl.ins_write) begin
                r_wptr <= w_wptr_next;
                r_wcnt <= r_wcnt + 1'b1;
            end
            if (i_ctrl.set_full) r_status <= ST_FULL;
            if (i_ctrl.exec && r_cmd == CMD_POLL && !r_poll_ready) r_status <= ST_NOT_READY;
        end
    end

    // Store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_ctrl.ins_write) begin
            r_mem[r_wptr] <= w_ins_word;
        end else if (i_ctrl.exec && r_cmd == CMD_INK_WR) begin
            r_mem[w_acc_addr] <= r_wdata;
        end
        if (i_ctrl.rd) r_mem_q <= r_mem[w_acc_addr];
    end

    // Result capture
    always_ff @(posedge i_clk) begin
        if (i_ctrl.finish) begin
            r_res_status <= r_status;
            unique case (r_cmd)
                CMD_INK_RD, CMD_STROKE_RD: r_res_rdata <= r_mem_q;
                CMD_INK_WR:                r_res_rdata <= r_wdata;
                default:                   r_res_rdata <= '0;
            endcase
            r_res_sample       <= r_last_sample;
            r_res_pen_up       <= r_pen_up;
            r_res_all_empty    <= (r_ink_idx == r_write_idx) && (r_stroke_idx == r_write_idx);
            r_res_ink_empty    <= (r_ink_idx == r_write_idx);
            r_res_stroke_empty <= (r_stroke_idx == r_ink_idx);
        end
    end

    assign o_done          = r_done;
    assign o_status        = r_res_status;
    assign o_read_data     = r_res_rdata;
    assign o_poll_sample   = r_res_sample;
    assign o_pen_is_up     = r_res_pen_up;
    assign o_all_empty     = r_res_all_empty;
    assign o_inker_empty   = r_res_ink_empty;
    assign o_stroker_empty = r_res_stroke_empty;

endmodule

>>> src/pen_sample_ring_queue.sv
// Top level of the pen sample ring queue: sequencer plus datapath.
//
//  Channel   Signals                                         Handshake
//  request   i_cmd i_sample_word i_sample_time i_current_ticks
//            i_offset i_write_data                           start & !busy
//  result    o_status o_read_data o_poll_sample o_pen_is_up
//            o_all_empty o_inker_empty o_stroker_empty       o_done, one cycle
//  config    i_cfg_idx i_cfg_data                            i_cfg_we
//
//  A queued insert of n words (n = 1, 2 or 4) writes them in S_INSERT between
//  S_DECODE and S_FINISH; every other command goes from S_DECODE straight to
//  S_FINISH. The single store port writes one word per cycle, which sets the
//  insert length. busy drops in the cycle the result is shown, so the next
//  request may be accepted then. Reset is synchronous, active low; the store
//  is not cleared. The receiver cannot stall: o_done is a single-cycle strobe.
module pen_sample_ring_queue
    import psrq_pkg::*;
#(
    parameter int BUFFER_DEPTH   = 256,
    parameter int PRESSURE_SHIFT = 0,
    parameter int PRESSURE_BITS  = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [CMD_W-1:0]     i_cmd,
    input  logic [WORD_W-1:0]    i_sample_word,
    input  logic [WORD_W-1:0]    i_sample_time,
    input  logic [WORD_W-1:0]    i_current_ticks,
    input  logic [OFFSET_W-1:0]  i_offset,
    input  logic [WORD_W-1:0]    i_write_data,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [WORD_W-1:0]    i_cfg_data,
    output logic                 o_done,
    output logic [STATUS_W-1:0]  o_status,
    output logic [WORD_W-1:0]    o_read_data,
    output logic [WORD_W-1:0]    o_poll_sample,
    output logic                 o_pen_is_up,
    output logic                 o_all_empty,
    output logic                 o_inker_empty,
    output logic                 o_stroker_empty
);

`include "pen_sample_ring_queue_macros.svh"

    t_dp_ctrl w_ctrl;
    t_dp_stat w_stat;

    // Sequencer
    psrq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_stat  (w_stat),
        .o_ctrl  (w_ctrl),
        .busy    (busy)
    );

    // Datapath
    psrq_datapath #(
        .BUFFER_DEPTH   (BUFFER_DEPTH),
        .PRESSURE_SHIFT (PRESSURE_SHIFT),
        .PRESSURE_BITS  (PRESSURE_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctrl          (w_ctrl),
        .o_stat          (w_stat),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_cmd           (i_cmd),
        .i_sample_word   (i_sample_word),
        .i_sample_time   (i_sample_time),
        .i_current_ticks (i_current_ticks),
        .i_offset        (i_offset),
        .i_write_data    (i_write_data),
        .o_done          (o_done),
        .o_status        (o_status),
        .o_read_data     (o_read_data),
        .o_poll_sample   (o_poll_sample),
        .o_pen_is_up     (o_pen_is_up),
        .o_all_empty     (o_all_empty),
        .o_inker_empty   (o_inker_empty),
        .o_stroker_empty (o_stroker_empty)
    );

    // Accepted request keeps the block busy until its result
    `PSRQ_ASSERT_NXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy,
        "accepted request did not make the block busy")
    // One result per request: strobes never come back to back
    `PSRQ_ASSERT_NXT(a_done_single, i_clk, i_rst_n, o_done, !o_done,
        "result strobe held for more than one cycle")
    // A result is only shown once the sequencer has released
    `PSRQ_ASSERT_IMP(a_done_idle, i_clk, i_rst_n, o_done, !busy,
        "result shown while a request is still in work")

endmodule

>>> tb/sv/pen_sample_ring_queue_checker.sv
// Response checker for the pen sample ring queue: mirrors the queue and compares each response.
`timescale 1ns / 100ps

module pen_sample_ring_queue_checker
    import psrq_pkg::*;
#(
    parameter int PRESSURE_SHIFT = 0,
    parameter int PRESSURE_BITS  = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic                 i_busy,
    input  logic [CMD_W-1:0]     i_cmd,
    input  logic [WORD_W-1:0]    i_sample_word,
    input  logic [WORD_W-1:0]    i_sample_time,
    input  logic [WORD_W-1:0]    i_current_ticks,
    input  logic [OFFSET_W-1:0]  i_offset,
    input  logic [WORD_W-1:0]    i_write_data,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [WORD_W-1:0]    i_cfg_data,
    input  logic                 i_done,
    input  logic [STATUS_W-1:0]  i_status,
    input  logic [WORD_W-1:0]    i_read_data,
    input  logic [WORD_W-1:0]    i_poll_sample,
    input  logic                 i_pen_is_up,
    input  logic                 i_all_empty,
    input  logic                 i_inker_empty,
    input  logic                 i_stroker_empty,
    output int                   o_mismatches,
    output int                   o_pending
);

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [WORD_W-1:0]   read_data;
        logic [WORD_W-1:0]   poll_sample;
        logic                pen_is_up;
        logic                all_empty;
        logic                inker_empty;
        logic                stroker_empty;
    } t_response;

    // Mirror of the queue; depth is 2**OFFSET_W so 8-bit indexes wrap by themselves
    logic [WORD_W-1:0]   ring [OFFSET_N];
    logic [OFFSET_W-1:0] wr_ptr;
    logic [OFFSET_W-1:0] ink_ptr;
    logic [OFFSET_W-1:0] stroke_ptr;
    logic [WORD_W-1:0]   last_word;
    logic                pen_up;
    logic                poll_rdy;

    // Mirror of the registers
    logic                poll_only;
    logic [WORD_W-1:0]   down_code;
    logic [WORD_W-1:0]   up_code;
    logic [WORD_W-1:0]   bad_code;

    t_response awaited_responses [$];
    int        mism = 0;

    task automatic reset_mirror();
        wr_ptr     = '0;
        ink_ptr    = '0;
        stroke_ptr = '0;
        last_word  = '0;
        pen_up     = 1'b1;
        poll_rdy   = 1'b0;
        poll_only  = 1'b0;
        down_code  = PEN_DOWN_RST;
        up_code    = PEN_UP_RST;
        bad_code   = INVALID_RST;
        awaited_responses.delete();
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
        case (idx)
            CFG_POLL_ONLY: begin
                poll_only = data[0];
                poll_rdy  = 1'b0;
            end
            CFG_PEN_DOWN: down_code = data;
            CFG_PEN_UP:   up_code   = data;
            CFG_INVALID:  bad_code  = data;
            default: ;
        endcase
    endtask

    // Poll record follows the pressure field of every word but the invalid code
    task automatic track_pressure(input logic [WORD_W-1:0] word);
        logic [WORD_W-1:0] z;
        if (word != bad_code) begin
            last_word = word;
            z = (word >> PRESSURE_SHIFT) & ((32'd1 << PRESSURE_BITS) - 32'd1);
            if (z == up_code) begin
                if (!pen_up) begin
                    pen_up   = 1'b1;
                    poll_rdy = 1'b1;
                end
            end else if (z == down_code) begin
                pen_up = 1'b0;
            end else if (z < WRITING_LIMIT) begin
                pen_up   = 1'b0;
                poll_rdy = 1'b1;
            end
        end
    endtask

    // Insert: pen codes carry a stamp, pen-up adds two fill words; all or nothing
    task automatic append_sample(input logic [WORD_W-1:0] word, input logic [WORD_W-1:0] stamp_in,
                                 input logic [WORD_W-1:0] ticks, output logic [STATUS_W-1:0] st);
        logic [WORD_W-1:0]   words [4];
        logic [WORD_W-1:0]   stamp;
        logic [OFFSET_W-1:0] probe;
        int                  n;
        logic                full;
        stamp = (stamp_in != '0) ? stamp_in : ticks;
        full  = 1'b0;
        st    = ST_OK;
        if (!poll_only) begin
            n        = 1;
            words[0] = word;
            if (word == down_code) begin
                words[1] = stamp;
                n        = 2;
            end else if (word == up_code) begin
                words[1] = stamp;
                words[2] = FILL_WORD;
                words[3] = FILL_WORD;
                n        = 4;
            end
            for (int k = 1; k <= n; k++) begin
                probe = wr_ptr + OFFSET_W'(k);
                if (probe == stroke_ptr)
                    full = 1'b1;
            end
            if (full) begin
                st = ST_FULL;
            end else begin
                for (int k = 0; k < n; k++) begin
                    probe       = wr_ptr + OFFSET_W'(k);
                    ring[probe] = words[k];
                end
                wr_ptr = wr_ptr + OFFSET_W'(n);
            end
        end
        if (!full)
            track_pressure(word);
    endtask

    // Work out the response of one accepted request and queue it
    task automatic compute_response();
        t_response           r;
        logic [OFFSET_W-1:0] addr;
        logic [STATUS_W-1:0] st;
        st = ST_OK;
        r  = '0;
        case (i_cmd)
            CMD_INSERT: append_sample(i_sample_word, i_sample_time, i_current_ticks, st);
            CMD_POLL: begin
                st       = poll_rdy ? ST_OK : ST_NOT_READY;
                poll_rdy = 1'b0;
            end
            CMD_INK_RD: begin
                addr        = ink_ptr + i_offset;
                r.read_data = ring[addr];
            end
            CMD_INK_WR: begin
                addr        = ink_ptr + i_offset;
                ring[addr]  = i_write_data;
                r.read_data = i_write_data;
            end
            CMD_INK_ADV:     ink_ptr = ink_ptr + i_offset;
            CMD_STROKE_RD: begin
                addr        = stroke_ptr + i_offset;
                r.read_data = ring[addr];
            end
            CMD_STROKE_ADV:  stroke_ptr = stroke_ptr + i_offset;
            CMD_FLUSH: begin
                ink_ptr    = wr_ptr;
                stroke_ptr = wr_ptr;
            end
            CMD_DROP_STROKE: stroke_ptr = ink_ptr;
            default: ;
        endcase
        r.status        = st;
        r.poll_sample   = last_word;
        r.pen_is_up     = pen_up;
        r.all_empty     = (ink_ptr == wr_ptr) && (stroke_ptr == wr_ptr);
        r.inker_empty   = (ink_ptr == wr_ptr);
        r.stroker_empty = (stroke_ptr == ink_ptr);
        awaited_responses.push_back(r);
    endtask

    task automatic check_field(input string name, input logic [WORD_W-1:0] want,
                               input logic [WORD_W-1:0] got);
        if (want !== got) begin
            if (mism < 10)
                $display("mismatch on %s: expected %h, got %h", name, want, got);
            mism++;
        end
    endtask

    task automatic check_response();
        t_response want;
        if (awaited_responses.size() == 0) begin
            if (mism < 10)
                $display("mismatch: response strobe with no request outstanding");
            mism++;
        end else begin
            want = awaited_responses.pop_front();
            check_field("status", WORD_W'(want.status), WORD_W'(i_status));
            check_field("read_data", want.read_data, i_read_data);
            check_field("poll_sample", want.poll_sample, i_poll_sample);
            check_field("pen_is_up", WORD_W'(want.pen_is_up), WORD_W'(i_pen_is_up));
            check_field("all_empty", WORD_W'(want.all_empty), WORD_W'(i_all_empty));
            check_field("inker_empty", WORD_W'(want.inker_empty), WORD_W'(i_inker_empty));
            check_field("stroker_empty", WORD_W'(want.stroker_empty), WORD_W'(i_stroker_empty));
        end
    endtask

    // Response of the previous request first, then register writes, then the new request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reset_mirror();
        end else begin
            if (i_done)
                check_response();
            if (i_cfg_we)
                write_register(i_cfg_idx, i_cfg_data);
            if (i_start && !i_busy)
                compute_response();
        end
        o_mismatches <= mism;
        o_pending    <= awaited_responses.size();
    end

endmodule

>>> tb/sv/pen_sample_ring_queue_tb.sv
// Testbench top for the pen sample ring queue: clock, reset, request stimulus and verdict.
`timescale 1ns / 100ps

module pen_sample_ring_queue_tb;
    import psrq_pkg::*;

    localparam int LIMIT_CYCLES = 200000;
    localparam int PHASES       = 7;
    localparam int RANDOM_ITEMS = 32;
    localparam int BURST_ITEMS  = 70;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    logic [CMD_W-1:0]     i_cmd;
    logic [WORD_W-1:0]    i_sample_word;
    logic [WORD_W-1:0]    i_sample_time;
    logic [WORD_W-1:0]    i_current_ticks;
    logic [OFFSET_W-1:0]  i_offset;
    logic [WORD_W-1:0]    i_write_data;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [WORD_W-1:0]    i_cfg_data;
    logic                 o_done;
    logic [STATUS_W-1:0]  o_status;
    logic [WORD_W-1:0]    o_read_data;
    logic [WORD_W-1:0]    o_poll_sample;
    logic                 o_pen_is_up;
    logic                 o_all_empty;
    logic                 o_inker_empty;
    logic                 o_stroker_empty;

    int mismatches;
    int pending;
    int cycles = 0;
    int idle_pct;

    // Register settings per phase; phase 0 runs on reset values
    logic              set_poll_only [PHASES];
    logic [WORD_W-1:0] set_down      [PHASES];
    logic [WORD_W-1:0] set_up        [PHASES];
    logic [WORD_W-1:0] set_bad       [PHASES];
    logic [WORD_W-1:0] cur_down;
    logic [WORD_W-1:0] cur_up;
    logic [WORD_W-1:0] cur_bad;

    pen_sample_ring_queue dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_cmd           (i_cmd),
        .i_sample_word   (i_sample_word),
        .i_sample_time   (i_sample_time),
        .i_current_ticks (i_current_ticks),
        .i_offset        (i_offset),
        .i_write_data    (i_write_data),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .o_done          (o_done),
        .o_status        (o_status),
        .o_read_data     (o_read_data),
        .o_poll_sample   (o_poll_sample),
        .o_pen_is_up     (o_pen_is_up),
        .o_all_empty     (o_all_empty),
        .o_inker_empty   (o_inker_empty),
        .o_stroker_empty (o_stroker_empty)
    );

    pen_sample_ring_queue_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .i_busy          (busy),
        .i_cmd           (i_cmd),
        .i_sample_word   (i_sample_word),
        .i_sample_time   (i_sample_time),
        .i_current_ticks (i_current_ticks),
        .i_offset        (i_offset),
        .i_write_data    (i_write_data),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_done          (o_done),
        .i_status        (o_status),
        .i_read_data     (o_read_data),
        .i_poll_sample   (o_poll_sample),
        .i_pen_is_up     (o_pen_is_up),
        .i_all_empty     (o_all_empty),
        .i_inker_empty   (o_inker_empty),
        .i_stroker_empty (o_stroker_empty),
        .o_mismatches    (mismatches),
        .o_pending       (pending)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES) begin
            $display("FAIL pen_sample_ring_queue");
            $finish;
        end
    end

    // Present one request and hold it until the block takes it
    task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [WORD_W-1:0] word,
                                input logic [WORD_W-1:0] stamp, input logic [WORD_W-1:0] ticks,
                                input logic [OFFSET_W-1:0] off, input logic [WORD_W-1:0] wdata);
        start           <= 1'b1;
        i_cmd           <= cmd;
        i_sample_word   <= word;
        i_sample_time   <= stamp;
        i_current_ticks <= ticks;
        i_offset        <= off;
        i_write_data    <= wdata;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic maybe_idle();
        int gap;
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            gap = $urandom_range(1, 19);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Hold off until every outstanding request has its response
    task automatic wait_drained();
        start <= 1'b0;
        do @(posedge i_clk); while (pending != 0 || busy);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    task automatic apply_setting(input int p);
        write_register(CFG_POLL_ONLY, WORD_W'(set_poll_only[p]));
        write_register(CFG_PEN_DOWN, set_down[p]);
        write_register(CFG_PEN_UP, set_up[p]);
        write_register(CFG_INVALID, set_bad[p]);
        i_cfg_we <= 1'b0;
        cur_down = set_down[p];
        cur_up   = set_up[p];
        cur_bad  = set_bad[p];
    endtask

    // Sample words lean on the live codes so every pen path is hit
    function automatic logic [WORD_W-1:0] pick_word(input bit pen_up_heavy);
        int kind;
        kind = $urandom_range(0, 9);
        if (pen_up_heavy && kind < 6)
            return cur_up;
        case (kind)
            0, 1:    return cur_down;
            2, 3:    return cur_up;
            4:       return cur_bad;
            5, 6:    return {28'($urandom_range(0, 32'h0FFF_FFFF)), 4'($urandom_range(0, 7))};
            default: return $urandom;
        endcase
    endfunction

    task automatic random_request(input bit insert_only);
        logic [CMD_W-1:0]    cmd;
        logic [WORD_W-1:0]   stamp;
        logic [OFFSET_W-1:0] off;
        int                  r;
        r = insert_only ? 0 : $urandom_range(0, 99);
        if (r < 50)      cmd = CMD_INSERT;
        else if (r < 56) cmd = CMD_POLL;
        else if (r < 63) cmd = CMD_INK_RD;
        else if (r < 69) cmd = CMD_INK_WR;
        else if (r < 76) cmd = CMD_INK_ADV;
        else if (r < 82) cmd = CMD_STROKE_RD;
        else if (r < 88) cmd = CMD_STROKE_ADV;
        else if (r < 91) cmd = CMD_FLUSH;
        else if (r < 94) cmd = CMD_DROP_STROKE;
        else             cmd = CMD_W'($urandom_range(9, 15));
        stamp = ($urandom_range(0, 3) == 0) ? '0 : WORD_W'($urandom);
        off   = ($urandom_range(0, 3) == 0) ? OFFSET_W'($urandom_range(0, 3))
                                            : OFFSET_W'($urandom_range(0, 255));
        send_request(cmd, pick_word(insert_only), stamp, $urandom, off, $urandom);
    endtask

    initial begin
        i_clk           = 1'b0;
        i_rst_n         = 1'b0;
        start           = 1'b0;
        i_cmd           = CMD_INSERT;
        i_sample_word   = '0;
        i_sample_time   = '0;
        i_current_ticks = '0;
        i_offset        = '0;
        i_write_data    = '0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = CFG_POLL_ONLY;
        i_cfg_data      = '0;
        idle_pct        = 20;
        cur_down        = PEN_DOWN_RST;
        cur_up          = PEN_UP_RST;
        cur_bad         = INVALID_RST;

        // Phase settings: extremes of every register, equal codes, small codes
        set_poll_only = '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0};
        set_down      = '{PEN_DOWN_RST, 32'd3, 32'd13, 32'd9, 32'd0, 32'd2, 32'hFFFF_FFFF};
        set_up        = '{PEN_UP_RST, 32'd5, 32'd14, 32'd9, 32'hFFFF_FFFF, 32'd0, 32'd0};
        set_bad       = '{INVALID_RST, 32'd7, 32'd0, 32'hFFFF_FFFF, $urandom, $urandom, 32'd8};

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Fill the whole store so that every later read hits a written entry
        for (int a = 0; a < OFFSET_N; a++) begin
            send_request(CMD_INK_WR, '0, '0, '0, OFFSET_W'(a), $urandom);
            maybe_idle();
        end

        // Directed: poll states, pen codes, pressure paths, offset wrap, reader moves
        send_request(CMD_POLL, '0, '0, '0, '0, '0);
        send_request(CMD_INSERT, 32'h0000_0000, '0, '0, '0, '0);
        send_request(CMD_POLL, '0, '0, '0, '0, '0);
        send_request(CMD_INSERT, cur_down, '0, 32'hFFFF_FFFF, '0, '0);
        send_request(CMD_INSERT, cur_up, 32'hFFFF_FFFF, 32'h1234_5678, '0, '0);
        send_request(CMD_INSERT, cur_bad, '0, '0, '0, '0);
        send_request(CMD_INSERT, 32'h0000_000F, '0, '0, '0, '0);
        send_request(CMD_INSERT, 32'hFFFF_FFF8, '0, '0, '0, '0);
        send_request(CMD_INSERT, 32'h0000_0003, '0, '0, '0, '0);
        send_request(CMD_INSERT, 32'h0000_00FE, '0, '0, '0, '0);
        send_request(CMD_INK_RD, '0, '0, '0, 8'd0, '0);
        send_request(CMD_INK_RD, '0, '0, '0, 8'd255, '0);
        send_request(CMD_INK_WR, '0, '0, '0, 8'd255, 32'hFFFF_FFFF);
        send_request(CMD_INK_WR, '0, '0, '0, 8'd0, 32'h0000_0000);
        send_request(CMD_STROKE_RD, '0, '0, '0, 8'd0, '0);
        send_request(CMD_STROKE_RD, '0, '0, '0, 8'd255, '0);
        send_request(CMD_INK_ADV, '0, '0, '0, 8'd255, '0);
        send_request(CMD_INK_ADV, '0, '0, '0, 8'd0, '0);
        send_request(CMD_STROKE_ADV, '0, '0, '0, 8'd1, '0);
        send_request(CMD_DROP_STROKE, '0, '0, '0, '0, '0);
        send_request(CMD_FLUSH, '0, '0, '0, '0, '0);
        // Stroker two ahead of the writer: multi-word inserts collide, one fits
        send_request(CMD_STROKE_ADV, '0, '0, '0, 8'd2, '0);
        send_request(CMD_INSERT, cur_up, '0, $urandom, '0, '0);
        send_request(CMD_INSERT, cur_down, $urandom, '0, '0, '0);
        send_request(CMD_INSERT, 32'h0000_0005, '0, '0, '0, '0);
        send_request(CMD_INSERT, 32'h0000_0005, '0, '0, '0, '0);
        send_request(CMD_W'(9), '0, '0, '0, '0, '0);
        send_request(CMD_W'(15), '0, '0, '0, '0, '0);

        // Random phases, one register setting each; the last one runs back to back
        for (int p = 0; p < PHASES; p++) begin
            if (p != 0) begin
                wait_drained();
                apply_setting(p);
            end
            idle_pct = (p == PHASES - 1) ? 0 : $urandom_range(0, 40);
            if (p == 1 || p == 4) begin
                for (int i = 0; i < BURST_ITEMS; i++) begin
                    random_request(1'b1);
                    maybe_idle();
                end
            end
            for (int i = 0; i < RANDOM_ITEMS; i++) begin
                random_request(1'b0);
                if (idle_pct != 0 && $urandom_range(0, 49) == 0)
                    wait_drained();
                else
                    maybe_idle();
            end
        end

        // Drain, then give the block a few more cycles for stray strobes
        wait_drained();
        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && pending == 0)
            $display("PASS pen_sample_ring_queue");
        else
            $display("FAIL pen_sample_ring_queue");
        $finish;
    end

endmodule
